>>> rtl/erct_pkg.sv
// erct_pkg: shared types and constants for the edge / region crossing time block
// no dependencies; imported by every module of the block
package erct_pkg;

    localparam int TIME_W      = 47;
    localparam int FIELD_W     = 32;
    localparam int MAG_W       = FIELD_W + 1;
    localparam int DT_SPLIT    = 24;
    localparam int LANE_LAT    = TIME_W + 2;
    localparam int N_LANES     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int IN_DATA_W   = 272;
    localparam int OUT_DATA_W  = 48;
    localparam int OUT_USER_W  = 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int F_SX_LSB    = 0;
    localparam int F_SY_LSB    = 32;
    localparam int F_ST_LSB    = 64;
    localparam int F_EX_LSB    = 111;
    localparam int F_EY_LSB    = 143;
    localparam int F_ET_LSB    = 175;
    localparam int F_AT_LSB    = 222;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_LOW_X  = 3'd1,
        CFG_LOW_Y  = 3'd2,
        CFG_HIGH_X = 3'd3,
        CFG_HIGH_Y = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                  two_dim;
        logic [FIELD_W-1:0]    lx;
        logic [FIELD_W-1:0]    ly;
        logic [FIELD_W-1:0]    hx;
        logic [FIELD_W-1:0]    hy;
    } region_cfg_t;

    typedef struct packed {
        logic              hit;
        logic              sub;
        logic [MAG_W-1:0]  num;
        logic [MAG_W-1:0]  den;
    } lane_cmd_t;

    typedef struct packed {
        logic                 two_dim;
        logic [TIME_W-1:0]    t1;
        logic [TIME_W-1:0]    dt_mag;
        logic [TIME_W-1:0]    after;
        lane_cmd_t [N_LANES-1:0] lane;
    } edge_cmd_t;

endpackage

>>> rtl/edge_rect_crossing_time_top.sv
// edge_rect_crossing_time_top: top level, configuration registers and stream packing
// depends on erct_pkg, erct_front, erct_queue, erct_back
//
// Takes one timed edge per request and answers a time strictly after after_time
// at which the edge crosses the boundary of the configured region: in an x
// interval when the mode bit is 0, the first such crossing along the edge; in the
// full rectangle when it is 1, the earliest one. One result comes back for every
// edge, in order. The block sustains one edge per clock while its queue is not
// full; a result passes four front stages, one queue slot, two multiply stages,
// a 47-stage pipelined long divider per lane and three select stages. The front
// and back are parted by a four-entry queue, so the front keeps taking edges while
// a result waits on m_tready, until the queue fills. Configuration writes are
// always accepted and should only be made while no edge is in flight.
module edge_rect_crossing_time_top
    import erct_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // start_x, start_y, start_time, end_x, end_y, end_time, after_time, zero pad
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cross_time, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // found
    output logic [OUT_USER_W-1:0] m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    region_cfg_t region_reg;

    logic              push, full, pop, empty, found;
    edge_cmd_t         q_wdata, q_rdata;
    logic [TIME_W-1:0] cross_time;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            region_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:   region_reg.two_dim <= cfg_data[0];
                CFG_LOW_X:  region_reg.lx      <= cfg_data;
                CFG_LOW_Y:  region_reg.ly      <= cfg_data;
                CFG_HIGH_X: region_reg.hx      <= cfg_data;
                CFG_HIGH_Y: region_reg.hy      <= cfg_data;
                default:    ;  // unknown index, write dropped
            endcase
        end
    end

    // front: classification of each edge into lane commands
    erct_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .region   (region_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (push),
        .cmd      (q_wdata),
        .full     (full)
    );

    erct_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .full  (full),
        .pop   (pop),
        .rdata (q_rdata),
        .empty (empty)
    );

    // back: interpolation, time bound and crossing select
    erct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_rdata),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_found (found),
        .out_time  (cross_time)
    );

    assign m_tdata = OUT_DATA_W'(cross_time);
    assign m_tuser = OUT_USER_W'(found);

endmodule

>>> rtl/erct_front.sv
// erct_front: accepts edges, computes differences, side tests and lane commands
// depends on erct_pkg
module erct_front
    import erct_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  region_cfg_t          region,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    output logic                 push,
    output edge_cmd_t            cmd,
    input  logic                 full
);

    localparam int W  = COORD_BITS;
    localparam int D  = W + 1;
    localparam int PW = 2 * D;
    localparam int CW = PW + 1;

    function automatic logic [1:0] cmp3(logic signed [D-1:0] a, logic signed [D-1:0] b);
        return {a < b, a > b};
    endfunction

    function automatic logic [1:0] sgn3(logic signed [CW-1:0] v);
        return {v[CW-1], |v};
    endfunction

    logic adv;

    // stage 0: captured request
    logic              v0_reg;
    logic [W-1:0]      x1_f0_reg, y1_f0_reg, x2_f0_reg, y2_f0_reg;
    logic [TIME_W-1:0] t1_f0_reg, t2_f0_reg, mt_f0_reg;

    // stage 1: differences and flags
    logic                   v1_reg, two_dim_f1_reg;
    logic signed [D-1:0]    ex_f1_reg, ey_f1_reg, dlx_f1_reg, dhx_f1_reg, dly_f1_reg, dhy_f1_reg;
    logic [N_LANES-1:0]     pass1_f1_reg;
    logic                   h1_f1_reg, h2_f1_reg, pick0_f1_reg, pick1_f1_reg, dt_neg_f1_reg;
    logic [TIME_W-1:0]      t1_f1_reg, dt_mag_f1_reg, mt_f1_reg;

    // stage 2: products and lane operands
    logic                   v2_reg, two_dim_f2_reg;
    logic signed [PW-1:0]   prod_a_reg, prod_b_reg, prod_c_reg, prod_e_reg;
    logic [N_LANES-1:0]     pass1_f2_reg, sub_f2_reg;
    logic                   h1_f2_reg, h2_f2_reg;
    logic [D-1:0]           num_f2_reg [N_LANES];
    logic [D-1:0]           den_f2_reg [N_LANES];
    logic [TIME_W-1:0]      t1_f2_reg, dt_mag_f2_reg, mt_f2_reg;

    // stage 3: finished command
    logic      v3_reg;
    edge_cmd_t cmd_reg;

    // stage 1 combinational
    logic signed [D-1:0] sx1, sy1, sx2, sy2, lx, ly, hx, hy;
    logic [TIME_W:0]     dt_w, dt_abs;
    logic                lt12, gt12, c_a, c_b, c_c, c_d, c_e, c_f, excl, gate1d;
    logic [N_LANES-1:0]  pass1;

    always_comb
    begin
        sx1 = $signed({x1_f0_reg[W-1], x1_f0_reg});
        sy1 = $signed({y1_f0_reg[W-1], y1_f0_reg});
        sx2 = $signed({x2_f0_reg[W-1], x2_f0_reg});
        sy2 = $signed({y2_f0_reg[W-1], y2_f0_reg});
        lx  = $signed({region.lx[W-1], region.lx[W-1:0]});
        ly  = $signed({region.ly[W-1], region.ly[W-1:0]});
        hx  = $signed({region.hx[W-1], region.hx[W-1:0]});
        hy  = $signed({region.hy[W-1], region.hy[W-1:0]});

        // first sign test against each axis-aligned side
        pass1[0] = (lx != hx) && (cmp3(sy1, ly) != cmp3(sy2, ly));
        pass1[1] = (ly != hy) && (cmp3(sx1, lx) != cmp3(sx2, lx));
        pass1[2] = (lx != hx) && (cmp3(sy1, hy) != cmp3(sy2, hy));
        pass1[3] = (ly != hy) && (cmp3(sx1, hx) != cmp3(sx2, hx));

        // x interval cases
        lt12 = sx1 < sx2;
        gt12 = sx1 > sx2;
        c_a  = lt12 && (sx1 < lx);
        c_b  = lt12 && (sx1 > lx) && (sx2 > hx);
        c_c  = lt12 && (sx1 < lx) && (sx2 > hx);
        c_d  = gt12 && (sx1 > hx);
        c_e  = gt12 && (sx1 < hx) && (sx2 < lx);
        c_f  = gt12 && (sx2 < lx) && (sx1 > hx);
        excl = ((sx1 > hx) && (sx2 > hx)) || ((sx1 < lx) && (sx2 < lx));
        gate1d = !region.two_dim && (t2_f0_reg > mt_f0_reg) && !excl;

        dt_w   = {1'b0, t2_f0_reg} - {1'b0, t1_f0_reg};
        dt_abs = dt_w[TIME_W] ? (~dt_w + 1'b1) : dt_w;
    end

    // stage 2 combinational: lane operands
    logic signed [D-1:0] num_s [N_LANES];
    logic signed [D-1:0] den_s [N_LANES];
    logic [D-1:0]        num_mag [N_LANES];
    logic [D-1:0]        den_mag [N_LANES];
    logic [N_LANES-1:0]  sub_s;

    always_comb
    begin
        num_s[0] = two_dim_f1_reg ? dly_f1_reg : (pick0_f1_reg ? dlx_f1_reg : dhx_f1_reg);
        den_s[0] = two_dim_f1_reg ? ey_f1_reg : ex_f1_reg;
        num_s[1] = two_dim_f1_reg ? dlx_f1_reg : (pick1_f1_reg ? dhx_f1_reg : dlx_f1_reg);
        den_s[1] = ex_f1_reg;
        num_s[2] = dhy_f1_reg;
        den_s[2] = ey_f1_reg;
        num_s[3] = dhx_f1_reg;
        den_s[3] = ex_f1_reg;
        for (int i = 0; i < N_LANES; i++)
        begin
            num_mag[i] = num_s[i][D-1] ? D'(-num_s[i]) : D'(num_s[i]);
            den_mag[i] = den_s[i][D-1] ? D'(-den_s[i]) : D'(den_s[i]);
            sub_s[i]   = num_s[i][D-1] ^ den_s[i][D-1] ^ dt_neg_f1_reg;
        end
    end

    // stage 3 combinational: corner cross products and second test
    logic signed [CW-1:0] c_ll, c_lr, c_ul, c_ur;
    logic [N_LANES-1:0]   pass2, hits;
    edge_cmd_t            cmd_next;

    always_comb
    begin
        c_ll = CW'(prod_a_reg) - CW'(prod_c_reg);
        c_lr = CW'(prod_a_reg) - CW'(prod_e_reg);
        c_ul = CW'(prod_b_reg) - CW'(prod_c_reg);
        c_ur = CW'(prod_b_reg) - CW'(prod_e_reg);
        pass2[0] = sgn3(c_ll) != sgn3(c_lr);
        pass2[1] = sgn3(c_ll) != sgn3(c_ul);
        pass2[2] = sgn3(c_ul) != sgn3(c_ur);
        pass2[3] = sgn3(c_lr) != sgn3(c_ur);
        hits = two_dim_f2_reg ? (pass1_f2_reg & pass2) : {2'b00, h2_f2_reg, h1_f2_reg};

        cmd_next.two_dim = two_dim_f2_reg;
        cmd_next.t1      = t1_f2_reg;
        cmd_next.dt_mag  = dt_mag_f2_reg;
        cmd_next.after   = mt_f2_reg;
        for (int i = 0; i < N_LANES; i++)
        begin
            cmd_next.lane[i].hit = hits[i];
            cmd_next.lane[i].sub = sub_f2_reg[i];
            cmd_next.lane[i].num = MAG_W'(num_f2_reg[i]);
            cmd_next.lane[i].den = MAG_W'(den_f2_reg[i]);
        end
    end

    assign adv      = !(v3_reg && full);
    assign s_tready = adv;
    assign push     = v3_reg && !full;
    assign cmd      = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_f0_reg <= s_tdata[F_SX_LSB +: W];
            y1_f0_reg <= s_tdata[F_SY_LSB +: W];
            t1_f0_reg <= s_tdata[F_ST_LSB +: TIME_W];
            x2_f0_reg <= s_tdata[F_EX_LSB +: W];
            y2_f0_reg <= s_tdata[F_EY_LSB +: W];
            t2_f0_reg <= s_tdata[F_ET_LSB +: TIME_W];
            mt_f0_reg <= s_tdata[F_AT_LSB +: TIME_W];

            two_dim_f1_reg <= region.two_dim;
            ex_f1_reg      <= sx2 - sx1;
            ey_f1_reg      <= sy2 - sy1;
            dlx_f1_reg     <= lx - sx1;
            dhx_f1_reg     <= hx - sx1;
            dly_f1_reg     <= ly - sy1;
            dhy_f1_reg     <= hy - sy1;
            pass1_f1_reg   <= pass1;
            h1_f1_reg      <= gate1d && (c_a || c_b || c_d || c_e);
            h2_f1_reg      <= gate1d && (c_c || c_f);
            pick0_f1_reg   <= c_a || c_e;
            pick1_f1_reg   <= c_c;
            dt_neg_f1_reg  <= dt_w[TIME_W];
            t1_f1_reg      <= t1_f0_reg;
            dt_mag_f1_reg  <= dt_abs[TIME_W-1:0];
            mt_f1_reg      <= mt_f0_reg;

            two_dim_f2_reg <= two_dim_f1_reg;
            prod_a_reg     <= ex_f1_reg * dly_f1_reg;
            prod_b_reg     <= ex_f1_reg * dhy_f1_reg;
            prod_c_reg     <= ey_f1_reg * dlx_f1_reg;
            prod_e_reg     <= ey_f1_reg * dhx_f1_reg;
            pass1_f2_reg   <= pass1_f1_reg;
            h1_f2_reg      <= h1_f1_reg;
            h2_f2_reg      <= h2_f1_reg;
            sub_f2_reg     <= sub_s;
            for (int i = 0; i < N_LANES; i++)
            begin
                num_f2_reg[i] <= num_mag[i];
                den_f2_reg[i] <= den_mag[i];
            end
            t1_f2_reg     <= t1_f1_reg;
            dt_mag_f2_reg <= dt_mag_f1_reg;
            mt_f2_reg     <= mt_f1_reg;

            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> rtl/erct_queue.sv
// erct_queue: short command queue between front and back
// depends on erct_pkg
module erct_queue
    import erct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  edge_cmd_t wdata,
    output logic      full,
    input  logic      pop,
    output edge_cmd_t rdata,
    output logic      empty
);

    edge_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign rdata = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

>>> rtl/erct_lane.sv
// erct_lane: one interpolation lane, split multiply then pipelined long division
// depends on erct_pkg
module erct_lane
    import erct_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  lane_cmd_t         cmd,
    input  logic [TIME_W-1:0] dt_mag,
    output logic [TIME_W-1:0] quot,
    output logic              hit,
    output logic              sub
);

    localparam int NW   = MAG_W + TIME_W;
    localparam int LO_W = DT_SPLIT;
    localparam int HI_W = TIME_W - DT_SPLIT;

    logic [MAG_W+LO_W-1:0] plo_reg;
    logic [MAG_W+HI_W-1:0] phi_reg;
    logic [MAG_W-1:0]      den_m1_reg;
    logic                  hit_m1_reg, sub_m1_reg;

    logic [MAG_W-1:0]  rem_reg  [TIME_W+1];
    logic [TIME_W-1:0] word_reg [TIME_W+1];
    logic [MAG_W-1:0]  den_reg  [TIME_W+1];
    logic              hit_reg  [TIME_W+1];
    logic              sub_reg  [TIME_W+1];

    logic [NW-1:0]     n_sum;
    logic [MAG_W:0]    trial    [TIME_W];
    logic [MAG_W:0]    diff     [TIME_W];
    logic              ge       [TIME_W];
    logic [MAG_W-1:0]  rem_next [TIME_W];
    logic [TIME_W-1:0] word_next[TIME_W];

    always_comb
    begin
        n_sum = (NW'(phi_reg) << LO_W) + NW'(plo_reg);
        // one quotient bit per stage
        for (int k = 0; k < TIME_W; k++)
        begin
            trial[k]     = {rem_reg[k], word_reg[k][TIME_W-1]};
            diff[k]      = trial[k] - {1'b0, den_reg[k]};
            ge[k]        = trial[k] >= {1'b0, den_reg[k]};
            rem_next[k]  = ge[k] ? diff[k][MAG_W-1:0] : trial[k][MAG_W-1:0];
            word_next[k] = {word_reg[k][TIME_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg    <= cmd.num * dt_mag[LO_W-1:0];
            phi_reg    <= cmd.num * dt_mag[TIME_W-1:LO_W];
            den_m1_reg <= cmd.den;
            hit_m1_reg <= cmd.hit;
            sub_m1_reg <= cmd.sub;

            rem_reg[0]  <= n_sum[NW-1:TIME_W];
            word_reg[0] <= n_sum[TIME_W-1:0];
            den_reg[0]  <= den_m1_reg;
            hit_reg[0]  <= hit_m1_reg;
            sub_reg[0]  <= sub_m1_reg;
            for (int k = 0; k < TIME_W; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                word_reg[k+1] <= word_next[k];
                den_reg[k+1]  <= den_reg[k];
                hit_reg[k+1]  <= hit_reg[k];
                sub_reg[k+1]  <= sub_reg[k];
            end
        end
    end

    assign quot = word_reg[TIME_W];
    assign hit  = hit_reg[TIME_W];
    assign sub  = sub_reg[TIME_W];

endmodule

>>> rtl/erct_back.sv
// erct_back: four interpolation lanes, time qualification and crossing select
// depends on erct_pkg and erct_lane
module erct_back
    import erct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  edge_cmd_t         cmd,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_found,
    output logic [TIME_W-1:0] out_time
);

    logic adv;

    logic [TIME_W-1:0] quot [N_LANES];
    logic              lhit [N_LANES];
    logic              lsub [N_LANES];

    // shared fields travel beside the lanes
    logic              dv_reg  [LANE_LAT];
    logic              dtd_reg [LANE_LAT];
    logic [TIME_W-1:0] dt1_reg [LANE_LAT];
    logic [TIME_W-1:0] dmt_reg [LANE_LAT];

    logic              r1_v_reg, r1_two_reg;
    logic [N_LANES-1:0] r1_ok_reg;
    logic [TIME_W-1:0] r1_tm_reg [N_LANES];

    logic              r2_v_reg;
    logic [1:0]        r2_ok_reg;
    logic [TIME_W-1:0] r2_tm_reg [2];
    logic              r2_two_reg;

    logic              out_v_reg, found_reg;
    logic [TIME_W-1:0] time_reg;

    assign adv = !out_v_reg || out_ready;
    assign pop = adv && !empty;

    for (genvar i = 0; i < N_LANES; i++)
    begin : g_lane
        erct_lane u_lane (
            .clk    (clk),
            .en     (adv),
            .cmd    (cmd.lane[i]),
            .dt_mag (cmd.dt_mag),
            .quot   (quot[i]),
            .hit    (lhit[i]),
            .sub    (lsub[i])
        );
    end

    logic [TIME_W-1:0]  tm [N_LANES];
    logic [N_LANES-1:0] ok;
    logic               take1, take3, take_hi;

    always_comb
    begin
        for (int i = 0; i < N_LANES; i++)
        begin
            tm[i] = lsub[i] ? (dt1_reg[LANE_LAT-1] - quot[i])
                            : (dt1_reg[LANE_LAT-1] + quot[i]);
            ok[i] = lhit[i] && (tm[i] > dmt_reg[LANE_LAT-1]);
        end
        // earliest wins in 2D, first side wins in 1D
        take1 = r1_ok_reg[1] && (!r1_ok_reg[0] || (r1_two_reg && (r1_tm_reg[1] < r1_tm_reg[0])));
        take3 = r1_ok_reg[3] && (!r1_ok_reg[2] || (r1_two_reg && (r1_tm_reg[3] < r1_tm_reg[2])));
        take_hi = r2_ok_reg[1] && (!r2_ok_reg[0] || (r2_two_reg && (r2_tm_reg[1] < r2_tm_reg[0])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANE_LAT; k++)
                dv_reg[k] <= 1'b0;
            r1_v_reg  <= 1'b0;
            r2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= !empty;
            for (int k = 1; k < LANE_LAT; k++)
                dv_reg[k] <= dv_reg[k-1];
            r1_v_reg  <= dv_reg[LANE_LAT-1];
            r2_v_reg  <= r1_v_reg;
            out_v_reg <= r2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dtd_reg[0] <= cmd.two_dim;
            dt1_reg[0] <= cmd.t1;
            dmt_reg[0] <= cmd.after;
            for (int k = 1; k < LANE_LAT; k++)
            begin
                dtd_reg[k] <= dtd_reg[k-1];
                dt1_reg[k] <= dt1_reg[k-1];
                dmt_reg[k] <= dmt_reg[k-1];
            end

            r1_two_reg <= dtd_reg[LANE_LAT-1];
            r1_ok_reg  <= ok;
            for (int i = 0; i < N_LANES; i++)
                r1_tm_reg[i] <= tm[i];

            r2_two_reg   <= r1_two_reg;
            r2_ok_reg[0] <= r1_ok_reg[0] || r1_ok_reg[1];
            r2_ok_reg[1] <= r1_ok_reg[2] || r1_ok_reg[3];
            r2_tm_reg[0] <= take1 ? r1_tm_reg[1] : r1_tm_reg[0];
            r2_tm_reg[1] <= take3 ? r1_tm_reg[3] : r1_tm_reg[2];

            found_reg <= r2_ok_reg[0] || r2_ok_reg[1];
            if (r2_ok_reg[0] || r2_ok_reg[1])
                time_reg <= take_hi ? r2_tm_reg[1] : r2_tm_reg[0];
            else
                time_reg <= '0;
        end
    end

    assign out_valid = out_v_reg;
    assign out_found = found_reg;
    assign out_time  = time_reg;

`ifndef ASSERT_OFF
    a_zero_when_missed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !found_reg) |-> (time_reg == '0))
        else $error("crossing time nonzero without a crossing");
`endif

endmodule

>>> bench/edge_rect_crossing_time_top_test.sv
// edge_rect_crossing_time_top_test: self-checking bench for the edge / region crossing time block
// drives timed edges and region settings, predicts each crossing time; needs erct_pkg and the top
module edge_rect_crossing_time_top_test;
    import erct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;   // index that the block ignores
    localparam longint TIME_MAX = (64'd1 << TIME_W) - 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;                       // idle wait after the last answer is back
    localparam int ITEMS_PER_PHASE = 141;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [31:0] sx, sy;
        logic [TIME_W-1:0]  st;
        logic signed [31:0] ex, ey;
        logic [TIME_W-1:0]  et, at;
    } edge_t;

    typedef struct {
        bit                found;
        logic [TIME_W-1:0] t;
    } crossing_t;

    // directed row: edge plus an optional hand-written answer
    typedef struct {
        edge_t     e;
        bit        typed;
        crossing_t ans;
    } row_t;

    typedef struct {
        bit                 two_dim;
        logic signed [31:0] lx, ly, hx, hy;
    } region_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the region registers
    region_t region = '{1'b0, 0, 0, 0, 0};

    crossing_t pending_crossings[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit quiet_sender = 1'b0;    // stretch with no sender gaps
    bit quiet_receiver = 1'b0;  // stretch with no receiver stalls
    int stall_left = 0;

    edge_rect_crossing_time_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // t1 + trunc(num * (t2 - t1) / den), quotient kept to the time width
    function automatic longint lerp_time(longint t1, longint t2, longint num, longint den);
        longint dt;
        logic [127:0] prod;
        logic [127:0] quo;
        longint q;
        bit sub;
        dt = t2 - t1;
        prod = 128'(abs64(num)) * 128'(abs64(dt));
        quo = prod / 128'(abs64(den));
        q = longint'({17'd0, quo[TIME_W-1:0]});
        sub = ((num < 0) != (dt < 0)) ? (den >= 0) : (den < 0);
        return sub ? t1 - q : t1 + q;
    endfunction

    // sign of a*d - b*c at full width
    function automatic int turn_sign(longint a, longint b, longint c, longint d);
        logic signed [127:0] wa, wb, wc, wd, p, q;
        wa = a; wb = b; wc = c; wd = d;
        p = wa * wd;
        q = wb * wc;
        return p > q ? 1 : (p < q ? -1 : 0);
    endfunction

    // side a-b against edge c-d, crossing time into tm
    function automatic bit side_hit(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy, longint dx, longint dy,
                                    longint t1, longint t2, output longint tm);
        tm = 0;
        if (turn_sign(bx - ax, by - ay, cx - ax, cy - ay) ==
            turn_sign(bx - ax, by - ay, dx - ax, dy - ay))
            return 1'b0;
        if (turn_sign(dx - cx, dy - cy, ax - cx, ay - cy) ==
            turn_sign(dx - cx, dy - cy, bx - cx, by - cy))
            return 1'b0;
        if (ax == bx && dx != cx)
        begin
            tm = lerp_time(t1, t2, ax - cx, dx - cx);
            return 1'b1;
        end
        if (ay == by && dy != cy)
        begin
            tm = lerp_time(t1, t2, ay - cy, dy - cy);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic crossing_t predict_crossing(edge_t e);
        longint x1, y1, x2, y2, t1, t2, mt, lx, ly, hx, hy, best, tm, v1, v2, mn, mx;
        longint sides[4][4];
        bit ok, h1, h2;
        crossing_t r;
        x1 = e.sx; y1 = e.sy; x2 = e.ex; y2 = e.ey;
        t1 = longint'({17'd0, e.st});
        t2 = longint'({17'd0, e.et});
        mt = longint'({17'd0, e.at});
        lx = region.lx; ly = region.ly; hx = region.hx; hy = region.hy;
        ok = 1'b0; best = 0; v1 = 0; v2 = 0; h1 = 1'b0; h2 = 1'b0;
        if (region.two_dim)
        begin
            sides = '{'{lx, ly, hx, ly}, '{lx, ly, lx, hy}, '{lx, hy, hx, hy}, '{hx, ly, hx, hy}};
            for (int i = 0; i < 4; i++)
                if (side_hit(sides[i][0], sides[i][1], sides[i][2], sides[i][3],
                             x1, y1, x2, y2, t1, t2, tm) && tm > mt && (!ok || tm < best))
                begin
                    best = tm;
                    ok = 1'b1;
                end
        end
        else if (t2 > mt)
        begin
            mn = x1 < x2 ? x1 : x2;
            mx = x1 < x2 ? x2 : x1;
            if (!(mn > hx || mx < lx))
            begin
                if (x1 < x2 && x1 < lx)
                begin
                    v1 = lerp_time(t1, t2, lx - x1, x2 - x1); h1 = 1'b1;
                end
                if (x1 < x2 && x1 > lx && x2 > hx)
                begin
                    v1 = lerp_time(t1, t2, hx - x1, x2 - x1); h1 = 1'b1;
                end
                if (x1 < x2 && x1 < lx && x2 > hx)
                begin
                    v2 = lerp_time(t1, t2, hx - x1, x2 - x1); h2 = 1'b1;
                end
                if (x1 > x2 && x1 > hx)
                begin
                    v1 = lerp_time(t1, t2, x1 - hx, x1 - x2); h1 = 1'b1;
                end
                if (x1 > x2 && x1 < hx && x2 < lx)
                begin
                    v1 = lerp_time(t1, t2, x1 - lx, x1 - x2); h1 = 1'b1;
                end
                if (x1 > x2 && x2 < lx && x1 > hx)
                begin
                    v2 = lerp_time(t1, t2, x1 - lx, x1 - x2); h2 = 1'b1;
                end
                if (h1 && v1 > mt) begin best = v1; ok = 1'b1; end
                else if (h2 && v2 > mt) begin best = v2; ok = 1'b1; end
            end
        end
        r.found = ok;
        r.t = ok ? best[TIME_W-1:0] : '0;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [TIME_W-1:0] any_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // mostly near a region corner, sometimes anything or an extreme
    function automatic logic signed [31:0] pick_coord(logic signed [31:0] a, logic signed [31:0] b);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom;
        if (r == 2) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        if (r == 3) return ($urandom_range(0, 1) ? a : b);
        return ($urandom_range(0, 1) ? a : b) + $signed($urandom_range(0, 200)) - 100;
    endfunction

    function automatic edge_t random_edge();
        edge_t e;
        longint base;
        e.sx = pick_coord(region.lx, region.hx);
        e.ex = pick_coord(region.lx, region.hx);
        e.sy = pick_coord(region.ly, region.hy);
        e.ey = pick_coord(region.ly, region.hy);
        if ($urandom_range(0, 19) == 0) e.ex = e.sx;   // vertical edge
        if ($urandom_range(0, 19) == 0) e.ey = e.sy;   // horizontal edge
        if ($urandom_range(0, 7) == 0)
        begin
            e.st = any_time();
            e.et = any_time();
            e.at = any_time();
        end
        else
        begin
            base = longint'($urandom_range(0, 100000));
            e.st = TIME_W'(base);
            e.et = ($urandom_range(0, 4) == 0) ?
                   TIME_W'(base - longint'($urandom_range(0, 5000))) :
                   TIME_W'(base + longint'($urandom_range(0, 5000)));
            case ($urandom_range(0, 3))
                0: e.at = '0;
                1: e.at = e.st;
                default: e.at = TIME_W'(base + longint'($urandom_range(0, 6000)) - 3000);
            endcase
        end
        return e;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_edge(edge_t e, bit typed, crossing_t ans);
        int gap;
        gap = quiet_sender ? 0 : gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, e.at, e.et, e.ey, e.ex, e.st, e.sy, e.sx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_crossings.push_back(typed ? ans : predict_crossing(e));
    endtask

    // cfg_valid stays high afterwards; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_MODE:   region.two_dim = value[0];
            CFG_LOW_X:  region.lx = value;
            CFG_LOW_Y:  region.ly = value;
            CFG_HIGH_X: region.hx = value;
            CFG_HIGH_Y: region.hy = value;
            default: ;
        endcase
    endtask

    task automatic set_region(region_t r);
        write_reg(CFG_MODE, {31'd0, r.two_dim});
        write_reg(CFG_LOW_X, r.lx);
        write_reg(CFG_LOW_Y, r.ly);
        write_reg(CFG_HIGH_X, r.hx);
        write_reg(CFG_HIGH_Y, r.hy);
        cfg_valid <= 1'b0;
    endtask

    // wait until every answer is back, then let the pipeline empty out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_crossings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- receiver side

    // random stalls on the result side, short mostly, now and then long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet_receiver && $urandom_range(0, 99) < 30)
                    stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(1, 3);
            end
        end
    end

    // compare each result against the oldest expected crossing
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_crossings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result found=%0d time=%0d", m_tuser[0],
                             m_tdata[TIME_W-1:0]);
            end
            else
            begin
                want = pending_crossings.pop_front();
                if (m_tuser[0] !== want.found || m_tdata[TIME_W-1:0] !== want.t ||
                    m_tdata[OUT_DATA_W-1:TIME_W] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected found=%0d time=%0d, got found=%0d time=%0d",
                                 want.found, want.t, m_tuser[0], m_tdata[TIME_W-1:0]);
                end
            end
        end
    end

    // watchdog: too long without any request or result moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        row_t rows[$];
        region_t phases[$];
        edge_t e;
        crossing_t none;

        none = '{1'b0, '0};
        // after reset: 1D mode, interval [0, 0]
        rows.push_back('{'{-10, 0, 0, 10, 0, 100, 0}, 1, '{1'b1, 47'd50}});
        rows.push_back('{'{10, 0, 0, -10, 0, 100, 0}, 1, '{1'b1, 47'd50}});
        // vertical edge never crosses
        rows.push_back('{'{0, 5, 0, 0, -5, 100, 0}, 1, none});
        // edge ends at the bound
        rows.push_back('{'{-10, 0, 0, 10, 0, 100, 100}, 1, none});
        // time running backwards
        rows.push_back('{'{-10, 0, 200, 10, 0, 100, 50}, 1, '{1'b1, 47'd150}});
        // starts exactly on the boundary
        rows.push_back('{'{0, 0, 0, 10, 0, 100, 0}, 1, none});
        // all times at maximum
        rows.push_back('{'{-10, 0, TIME_MAX, 10, 0, TIME_MAX, TIME_MAX}, 1, none});
        // coordinate and time extremes, checked by prediction
        rows.push_back('{'{32'sh80000000, 32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff,
                           TIME_MAX, 0}, 0, none});
        rows.push_back('{'{32'sh7fffffff, -1, TIME_MAX, 32'sh80000000, 0, 0, 0}, 0, none});
        rows.push_back('{'{-1, 32'sh7fffffff, 1, 1, 32'sh80000000, TIME_MAX, 1}, 0, none});
        rows.push_back('{'{32'sh80000000, 0, 47'h555555555555, 1, 0, 47'h2aaaaaaaaaaa, 3},
                         0, none});

        phases.push_back('{1'b1, -100, -50, 100, 50});
        phases.push_back('{1'b0, -1000, 7, 1000, -7});
        phases.push_back('{1'b1, 0, 0, 0, 0});                    // degenerate region
        phases.push_back('{1'b1, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff});
        phases.push_back('{1'b0, 100, 0, -100, 0});               // inverted interval
        phases.push_back('{1'b1, 50, -20, -50, 20});              // inverted rectangle
        phases.push_back('{1'b0, 32'sh80000000, 0, 32'sh7fffffff, 0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_edge(rows[i].e, rows[i].typed, rows[i].ans);
        drain();

        // an unknown index must leave the region alone
        write_reg(CFG_UNUSED, 32'hffffffff);
        cfg_valid <= 1'b0;
        @(posedge clk);

        foreach (phases[p])
        begin
            set_region(phases[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                begin
                    quiet_sender = ($urandom_range(0, 3) == 0);
                    quiet_receiver = ($urandom_range(0, 3) == 0);
                end
                e = random_edge();
                send_edge(e, 1'b0, none);
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/erct_pkg.sv
rtl/erct_front.sv
rtl/erct_queue.sv
rtl/erct_lane.sv
rtl/erct_back.sv
rtl/edge_rect_crossing_time_top.sv
bench/edge_rect_crossing_time_top_test.sv
